[rtl/lbs_pkg.sv]
// Shared types and constants for the LED blink sequencer.
// No dependencies; compiled first.
`default_nettype none

package lbs_pkg;

	// Field widths
	localparam int CMD_W   = 2;
	localparam int RGB_W   = 24;
	localparam int MS_W    = 16;
	localparam int BLANK_W = 24;
	localparam int PCT_W   = 7;
	localparam int LVL_W   = 8;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_QUEUE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_OFF   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

	// Register indexes (byte address = 4 * index)
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_BRIGHT    = 3'd0;
	localparam logic [2:0] REG_RED_GAIN  = 3'd1;
	localparam logic [2:0] REG_GRN_GAIN  = 3'd2;
	localparam logic [2:0] REG_BLU_GAIN  = 3'd3;
	localparam logic [2:0] REG_SEP       = 3'd4;
	localparam logic [2:0] REG_DEF_BLANK = 3'd5;

	// Register reset values
	localparam logic [PCT_W-1:0]   PCT_RST       = 7'd100;
	localparam logic [MS_W-1:0]    SEP_RST       = 16'd500;
	localparam logic [BLANK_W-1:0] DEF_BLANK_RST = 24'd0;

	// x / 100 == (x * RECIP_100) >> RECIP_SHIFT, exact for x < 43690
	localparam int               RECIP_SHIFT = 22;
	localparam logic [15:0]      RECIP_100   = 16'd41944;
	localparam logic [LVL_W-1:0] LVL_MAX     = 8'hFF;

	// Gain settings handed to the scaler
	typedef struct packed {
		logic [PCT_W-1:0] bright;
		logic [PCT_W-1:0] red;
		logic [PCT_W-1:0] green;
		logic [PCT_W-1:0] blue;
	} lbs_gain_t;

endpackage

`default_nettype wire

[rtl/lbs_item_if.sv]
// Input item channel: valid/ready handshake plus command payload.
// Depends on lbs_pkg.
`default_nettype none

interface lbs_item_if;
	import lbs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [RGB_W-1:0]     color;
	logic [MS_W-1:0]      hold_ms;
	logic [MS_W-1:0]      gap_ms;
	logic [BLANK_W-1:0]   blank_time;

	modport source (output valid, command, color, hold_ms, gap_ms, blank_time, input ready);
	modport sink   (input valid, command, color, hold_ms, gap_ms, blank_time, output ready);
endinterface

`default_nettype wire

[rtl/lbs_result_if.sv]
// Result channel: valid/ready handshake plus scaled color payload.
// Depends on lbs_pkg.
`default_nettype none

interface lbs_result_if;
	import lbs_pkg::*;

	logic              valid;
	logic              ready;
	logic [LVL_W-1:0]  red;
	logic [LVL_W-1:0]  green;
	logic [LVL_W-1:0]  blue;
	logic [MS_W-1:0]   hold_time_ms;
	logic              last;

	modport source (output valid, red, green, blue, hold_time_ms, last, input ready);
	modport sink   (input valid, red, green, blue, hold_time_ms, last, output ready);
endinterface

`default_nettype wire

[rtl/lbs_scaler.sv]
// Gain and brightness scaler: one shared 16x16 multiplier for all three channels.
// Depends on lbs_pkg.
`default_nettype none

module lbs_scaler (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [23:0]              rgb,
	input  lbs_pkg::lbs_gain_t       gain,
	output logic                     done,
	output logic [7:0]               red,
	output logic [7:0]               green,
	output logic [7:0]               blue
);
	import lbs_pkg::*;

	// Per channel: chan*gain, /100, *bright, /100 (one multiply per phase)
	localparam logic [1:0] PH_GAIN  = 2'd0;
	localparam logic [1:0] PH_DIV1  = 2'd1;
	localparam logic [1:0] PH_BRT   = 2'd2;
	localparam logic [1:0] PH_DIV2  = 2'd3;
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	logic             busy_q;
	logic [1:0]       chan_q;
	logic [1:0]       phase_q;
	logic [23:0]      rgb_q;
	logic [15:0]      acc_q;
	logic [7:0]       chan_val;
	logic [PCT_W-1:0] gain_sel;
	logic [15:0]      op_a;
	logic [15:0]      op_b;
	logic [31:0]      prod;
	logic [9:0]       quot;
	logic [7:0]       lvl_sat;

	// Channel and gain select
	always_comb begin
		case (chan_q)
			CH_RED: begin
				chan_val = rgb_q[23:16];
				gain_sel = gain.red;
			end
			CH_GREEN: begin
				chan_val = rgb_q[15:8];
				gain_sel = gain.green;
			end
			default: begin
				chan_val = rgb_q[7:0];
				gain_sel = gain.blue;
			end
		endcase
	end

	// Shared multiplier operands
	always_comb begin
		case (phase_q)
			PH_GAIN: begin
				op_a = {8'd0, chan_val};
				op_b = {9'd0, gain_sel};
			end
			PH_BRT: begin
				op_a = acc_q;
				op_b = {9'd0, gain.bright};
			end
			default: begin
				op_a = acc_q;
				op_b = RECIP_100;
			end
		endcase
	end

	assign prod    = op_a * op_b;
	assign quot    = prod[31:RECIP_SHIFT];
	assign lvl_sat = (quot > 10'd255) ? LVL_MAX : quot[7:0];
	assign done    = busy_q && (phase_q == PH_DIV2) && (chan_q == CH_BLUE);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			chan_q  <= CH_RED;
			phase_q <= PH_GAIN;
		end else if (start) begin
			busy_q  <= 1'b1;
			chan_q  <= CH_RED;
			phase_q <= PH_GAIN;
		end else if (busy_q) begin
			phase_q <= phase_q + 2'd1;
			if (phase_q == PH_DIV2) begin
				if (chan_q == CH_BLUE) begin
					busy_q <= 1'b0;
				end else begin
					chan_q <= chan_q + 2'd1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			rgb_q <= rgb;
		end
		if (busy_q) begin
			acc_q <= phase_q[0] ? {6'd0, quot} : prod[15:0];
			if (phase_q == PH_DIV2) begin
				case (chan_q)
					CH_RED:   red   <= lvl_sat;
					CH_GREEN: green <= lvl_sat;
					default:  blue  <= lvl_sat;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

[rtl/led_blink_sequencer.sv]
// Top level of the LED blink sequencer: APB registers, item decode, emit sequencer.
// Depends on lbs_pkg, lbs_item_if, lbs_result_if and lbs_scaler.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  item     | in        | command, color, hold_ms, gap_ms, blank_time
//  result   | out       | red, green, blue, hold_time_ms, last
//  apb      | in / out  | six registers at byte addresses 0x00..0x14
//
// An item is taken only while idle; an unused command, or a tick that does not end
// its countdown, leaves the block idle. Each result passes through a select state,
// the shared multiplier of the scaler (3 channels x 4 multiplies) and an output
// state. item.ready is high only while idle; a stalled result holds its register
// until the transfer.
// Reset clears state and loads register defaults; no clearing pass.
`default_nettype none

module led_blink_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lbs_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	lbs_item_if.sink                      item,
	lbs_result_if.source                  result
);
	import lbs_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PICK  = 2'd1;
	localparam logic [1:0] S_SCALE = 2'd2;
	localparam logic [1:0] S_OUT   = 2'd3;

	// Emit slots, served lowest first
	localparam int SL_SEP1  = 0;
	localparam int SL_BLINK = 1;
	localparam int SL_SEP2  = 2;
	localparam int SL_REST  = 3;

	logic [1:0]         state_q;
	logic [PCT_W-1:0]   bright_q;
	logic [PCT_W-1:0]   red_gain_q;
	logic [PCT_W-1:0]   grn_gain_q;
	logic [PCT_W-1:0]   blu_gain_q;
	logic [MS_W-1:0]    sep_q;
	logic [BLANK_W-1:0] def_blank_q;

	logic [RGB_W-1:0]   shown_q;
	logic [RGB_W-1:0]   rest_color_q;
	logic [BLANK_W-1:0] rest_blank_q;
	logic [BLANK_W-1:0] blank_cnt_q;
	logic               blank_armed_q;
	logic [3:0]         mask_q;

	logic [RGB_W-1:0]   color_q;
	logic [MS_W-1:0]    hold_q;
	logic [MS_W-1:0]    gap_q;
	logic [MS_W-1:0]    out_hold_q;
	logic               out_last_q;

	logic               wr_en;
	logic [2:0]         reg_idx;
	logic               take;
	logic [3:0]         pick_bit;
	logic [RGB_W-1:0]   pick_rgb;
	logic [MS_W-1:0]    pick_hold;
	logic               pick_last;
	logic               sep1_need;
	logic               sep2_need;
	logic               scale_done;
	lbs_gain_t          gain;

	// APB register port
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q    <= PCT_RST;
			red_gain_q  <= PCT_RST;
			grn_gain_q  <= PCT_RST;
			blu_gain_q  <= PCT_RST;
			sep_q       <= SEP_RST;
			def_blank_q <= DEF_BLANK_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BRIGHT:    bright_q    <= pwdata[PCT_W-1:0];
				REG_RED_GAIN:  red_gain_q  <= pwdata[PCT_W-1:0];
				REG_GRN_GAIN:  grn_gain_q  <= pwdata[PCT_W-1:0];
				REG_BLU_GAIN:  blu_gain_q  <= pwdata[PCT_W-1:0];
				REG_SEP:       sep_q       <= pwdata[MS_W-1:0];
				REG_DEF_BLANK: def_blank_q <= pwdata[BLANK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BRIGHT:    prdata = {25'd0, bright_q};
			REG_RED_GAIN:  prdata = {25'd0, red_gain_q};
			REG_GRN_GAIN:  prdata = {25'd0, grn_gain_q};
			REG_BLU_GAIN:  prdata = {25'd0, blu_gain_q};
			REG_SEP:       prdata = {16'd0, sep_q};
			REG_DEF_BLANK: prdata = {8'd0, def_blank_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign gain = '{bright: bright_q, red: red_gain_q, green: grn_gain_q, blue: blu_gain_q};

	// Item decode
	assign item.ready = (state_q == S_IDLE);
	assign take       = item.valid && item.ready;
	assign sep1_need  = (item.color == shown_q) && (item.color != '0);
	assign sep2_need  = (item.color == rest_color_q) && (item.color != '0);

	// Next emit slot
	always_comb begin
		if (mask_q[SL_SEP1]) begin
			pick_bit  = 4'b0001;
			pick_rgb  = '0;
			pick_hold = sep_q;
		end else if (mask_q[SL_BLINK]) begin
			pick_bit  = 4'b0010;
			pick_rgb  = color_q;
			pick_hold = hold_q;
		end else if (mask_q[SL_SEP2]) begin
			pick_bit  = 4'b0100;
			pick_rgb  = '0;
			pick_hold = sep_q;
		end else begin
			pick_bit  = 4'b1000;
			pick_rgb  = rest_color_q;
			pick_hold = (gap_q != '0) ? gap_q : sep_q;
		end
		pick_last = ((mask_q & ~pick_bit) == 4'b0000);
	end

	// Sequencer and indicator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mask_q        <= 4'b0000;
			shown_q       <= '0;
			rest_color_q  <= '0;
			rest_blank_q  <= DEF_BLANK_RST;
			blank_cnt_q   <= '0;
			blank_armed_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						case (item.command)
							CMD_QUEUE: begin
								state_q <= S_PICK;
								if (item.hold_ms != '0) begin
									mask_q <= {1'b1, sep2_need, 1'b1, sep1_need};
								end else begin
									mask_q       <= 4'b0010;
									rest_color_q <= item.color;
									rest_blank_q <= item.blank_time;
								end
							end
							CMD_OFF: begin
								state_q      <= S_PICK;
								mask_q       <= 4'b0010;
								rest_color_q <= '0;
								rest_blank_q <= '0;
							end
							CMD_TICK: begin
								if (blank_armed_q) begin
									if (blank_cnt_q <= 24'd1) begin
										state_q      <= S_PICK;
										mask_q       <= 4'b0010;
										rest_color_q <= '0;
										rest_blank_q <= '0;
									end else begin
										blank_cnt_q <= blank_cnt_q - 24'd1;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_PICK: begin
					// emitted color decides the blanking countdown
					shown_q <= pick_rgb;
					mask_q  <= mask_q & ~pick_bit;
					state_q <= S_SCALE;
					if ((pick_rgb != '0) && (rest_blank_q != '0)) begin
						blank_armed_q <= 1'b1;
						blank_cnt_q   <= rest_blank_q;
					end else begin
						blank_armed_q <= 1'b0;
						blank_cnt_q   <= '0;
					end
				end
				S_SCALE: begin
					if (scale_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (result.ready) begin
						state_q <= (mask_q != 4'b0000) ? S_PICK : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item payload and result side fields
	always_ff @(posedge clk) begin
		if (take) begin
			case (item.command)
				CMD_QUEUE: begin
					color_q <= item.color;
					hold_q  <= item.hold_ms;
					gap_q   <= item.gap_ms;
				end
				default: begin
					color_q <= '0;
					hold_q  <= '0;
				end
			endcase
		end
		if (state_q == S_PICK) begin
			out_hold_q <= pick_hold;
			out_last_q <= pick_last;
		end
	end

	// Shared scaler
	lbs_scaler u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_PICK),
		.rgb    (pick_rgb),
		.gain   (gain),
		.done   (scale_done),
		.red    (result.red),
		.green  (result.green),
		.blue   (result.blue)
	);

	assign result.valid        = (state_q == S_OUT);
	assign result.hold_time_ms = out_hold_q;
	assign result.last         = out_last_q;

`ifndef ASSERT_OFF
	// No result is offered while a new item can be taken
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !result.valid)
		else $error("item ready while a result is pending");

	// An armed countdown never sits at zero
	a_armed_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		blank_armed_q |-> (blank_cnt_q != '0))
		else $error("blanking countdown armed at zero");

	// The final result of an item frees the input side
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && result.last) |=> item.ready)
		else $error("block busy after final result transfer");

	// Scaler finishes only while the sequencer waits for it
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		scale_done |-> (state_q == S_SCALE))
		else $error("scaler done outside the scale state");
`endif

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for led_blink_sequencer: directed table, then random phases.
// Depends on lbs_pkg, lbs_item_if, lbs_result_if and the led_blink_sequencer RTL.
// A local model of the color sequencer predicts every result transfer;
// APB registers are read back.
`default_nettype none

module tb_top;
	import lbs_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int NUM_REGS     = 6;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 60;
	localparam int MAX_IDLE     = 13;
	localparam int DRAIN_CYCLES = 60;

	// one input transfer
	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [RGB_W-1:0]   color;
		logic [MS_W-1:0]    hold_ms;
		logic [MS_W-1:0]    gap_ms;
		logic [BLANK_W-1:0] blank_time;
	} led_req_t;

	// one result transfer
	typedef struct packed {
		logic [LVL_W-1:0] red;
		logic [LVL_W-1:0] green;
		logic [LVL_W-1:0] blue;
		logic [MS_W-1:0]  hold;
		logic             last;
	} led_frame_t;

	// directed row: request, plus a hand-written single result (hold 0) where obvious
	typedef struct packed {
		led_req_t         req;
		logic             known;
		logic [RGB_W-1:0] known_rgb;
	} led_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	lbs_item_if   item_ch ();
	lbs_result_if result_ch ();

	led_blink_sequencer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	// register shadow
	logic [PCT_W-1:0]   cfg_bright    = PCT_RST;
	logic [PCT_W-1:0]   cfg_gain_r    = PCT_RST;
	logic [PCT_W-1:0]   cfg_gain_g    = PCT_RST;
	logic [PCT_W-1:0]   cfg_gain_b    = PCT_RST;
	logic [MS_W-1:0]    cfg_sep       = SEP_RST;
	logic [BLANK_W-1:0] cfg_def_blank = DEF_BLANK_RST;

	// sequencer state shadow
	logic [RGB_W-1:0]   shown_rgb  = '0;
	logic [RGB_W-1:0]   rest_rgb   = '0;
	logic [BLANK_W-1:0] rest_blank = DEF_BLANK_RST;
	logic [BLANK_W-1:0] blank_left = '0;
	logic               blank_on   = 1'b0;

	led_frame_t fresh_frames[$];
	led_frame_t pending_frames[$];
	logic [RGB_W-1:0] palette [4];

	int  errors     = 0;
	int  n_reqs     = 0;
	int  n_frames   = 0;
	int  n_writes   = 0;
	bit  send_idle  = 1'b0;
	bit  take_idle  = 1'b0;

	led_row_t directed_rows [23] = '{
		{CMD_OFF,    24'h000000, 16'h0000, 16'h0000, 24'h000000, 1'b1, 24'h000000},
		{CMD_QUEUE,  24'hFFFFFF, 16'h0000, 16'h0000, 24'h000000, 1'b1, 24'hFFFFFF},
		{CMD_QUEUE,  24'hFFFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0, 24'h000000},
		{CMD_QUEUE,  24'h123456, 16'h0001, 16'h0000, 24'h000000, 1'b0, 24'h000000},
		{CMD_QUEUE,  24'h000000, 16'h0000, 16'h0000, 24'hFFFFFF, 1'b1, 24'h000000},
		{CMD_QUEUE,  24'h800000, 16'h0000, 16'h0000, 24'h000003, 1'b1, 24'h800000},
		{CMD_TICK,   24'h000000, 16'h0000, 16'h0000, 24'h000000, 1'b0, 24'h000000},
		{CMD_TICK,   24'hFFFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0, 24'h000000},
		{CMD_TICK,   24'h000000, 16'h0000, 16'h0000, 24'h000000, 1'b1, 24'h000000},
		{CMD_TICK,   24'h000000, 16'h0000, 16'h0000, 24'h000000, 1'b0, 24'h000000},
		{CMD_UNUSED, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0, 24'h000000},
		{CMD_QUEUE,  24'h00FF00, 16'h0000, 16'h0000, 24'h000001, 1'b1, 24'h00FF00},
		{CMD_QUEUE,  24'h00FF00, 16'h0007, 16'h0009, 24'h000000, 1'b0, 24'h000000},
		{CMD_TICK,   24'h000000, 16'h0000, 16'h0000, 24'h000000, 1'b1, 24'h000000},
		{CMD_QUEUE,  24'h0000FF, 16'h0000, 16'h0000, 24'h000002, 1'b1, 24'h0000FF},
		{CMD_OFF,    24'hFFFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1, 24'h000000},
		{CMD_TICK,   24'h000000, 16'h0000, 16'h0000, 24'h000000, 1'b0, 24'h000000},
		{CMD_QUEUE,  24'h000001, 16'h0005, 16'h0000, 24'h000000, 1'b0, 24'h000000},
		{CMD_QUEUE,  24'hAA55AA, 16'h0000, 16'h0000, 24'hFFFFFF, 1'b1, 24'hAA55AA},
		{CMD_QUEUE,  24'hAA55AA, 16'hFFFF, 16'h0001, 24'h000000, 1'b0, 24'h000000},
		{CMD_QUEUE,  24'h555555, 16'h0000, 16'h0000, 24'h000000, 1'b1, 24'h555555},
		{CMD_UNUSED, 24'h000000, 16'h0000, 16'h0000, 24'h000000, 1'b0, 24'h000000},
		{CMD_QUEUE,  24'h000000, 16'h0001, 16'h0000, 24'h000000, 1'b0, 24'h000000}
	};

	// gain, then brightness, both truncating; saturates above full scale
	function automatic logic [LVL_W-1:0] scale_level(logic [7:0] chan,
			logic [PCT_W-1:0] gain);
		int unsigned lvl;
		lvl = (int'(chan) * int'(gain)) / 100;
		lvl = (lvl * int'(cfg_bright)) / 100;
		if (lvl > 255)
			lvl = 255;
		return lvl[LVL_W-1:0];
	endfunction

	// queue one displayed color and re-arm or cancel the blanking countdown
	function automatic void show_rgb(logic [RGB_W-1:0] rgb, logic [MS_W-1:0] hold);
		led_frame_t f;
		f.red   = scale_level(rgb[23:16], cfg_gain_r);
		f.green = scale_level(rgb[15:8], cfg_gain_g);
		f.blue  = scale_level(rgb[7:0], cfg_gain_b);
		f.hold  = hold;
		f.last  = 1'b0;
		fresh_frames.push_back(f);
		shown_rgb = rgb;
		if (rgb != '0 && rest_blank != '0) begin
			blank_on   = 1'b1;
			blank_left = rest_blank;
		end else begin
			blank_on   = 1'b0;
			blank_left = '0;
		end
	endfunction

	function automatic void set_rest(logic [RGB_W-1:0] rgb, logic [BLANK_W-1:0] blank);
		rest_rgb   = rgb;
		rest_blank = blank;
		show_rgb(rgb, '0);
	endfunction

	// sequence for one accepted request, left in fresh_frames
	function automatic void plan_sequence(led_req_t req);
		fresh_frames.delete();
		case (req.command)
			CMD_QUEUE: begin
				if (req.hold_ms != '0) begin
					if (req.color == shown_rgb && req.color != '0)
						show_rgb('0, cfg_sep);
					show_rgb(req.color, req.hold_ms);
					if (req.color == rest_rgb && req.color != '0)
						show_rgb('0, cfg_sep);
					show_rgb(rest_rgb, (req.gap_ms != '0) ? req.gap_ms : cfg_sep);
				end else begin
					set_rest(req.color, req.blank_time);
				end
			end
			CMD_OFF: set_rest('0, '0);
			CMD_TICK: begin
				if (blank_on) begin
					if (blank_left <= 1)
						set_rest('0, '0);
					else
						blank_left = blank_left - 1'b1;
				end
			end
			default: ;
		endcase
		if (fresh_frames.size() > 0)
			fresh_frames[fresh_frames.size()-1].last = 1'b1;
	endfunction

	function automatic logic [31:0] reg_value(logic [2:0] idx);
		case (idx)
			REG_BRIGHT:    return 32'(cfg_bright);
			REG_RED_GAIN:  return 32'(cfg_gain_r);
			REG_GRN_GAIN:  return 32'(cfg_gain_g);
			REG_BLU_GAIN:  return 32'(cfg_gain_b);
			REG_SEP:       return 32'(cfg_sep);
			REG_DEF_BLANK: return 32'(cfg_def_blank);
			default:       return 32'd0;
		endcase
	endfunction

	function automatic logic [RGB_W-1:0] pick_color();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 35)
			return palette[$urandom_range(0, 3)];
		else if (k < 45)
			return shown_rgb;
		else if (k < 55)
			return rest_rgb;
		else if (k < 62)
			return '0;
		else if (k < 67)
			return '1;
		return RGB_W'($urandom);
	endfunction

	// mostly blinks, rests with short blank times and ticks, so countdowns expire often
	function automatic led_req_t make_req();
		led_req_t r;
		int unsigned k;
		int unsigned b;
		r.color      = pick_color();
		r.hold_ms    = MS_W'($urandom);
		r.gap_ms     = MS_W'($urandom);
		r.blank_time = BLANK_W'($urandom);
		k = $urandom_range(0, 99);
		if (k < 30) begin
			r.command = CMD_QUEUE;
			b = $urandom_range(0, 19);
			if (b < 2)
				r.hold_ms = 16'd1;
			else if (b < 3)
				r.hold_ms = '1;
			else if (r.hold_ms == '0)
				r.hold_ms = 16'd1;
			if ($urandom_range(0, 9) < 3)
				r.gap_ms = '0;
		end else if (k < 50) begin
			r.command = CMD_QUEUE;
			r.hold_ms = '0;
			b = $urandom_range(0, 19);
			if (b < 12)
				r.blank_time = BLANK_W'($urandom_range(1, 6));
			else if (b < 16)
				r.blank_time = '0;
			else if (b < 19)
				r.blank_time = BLANK_W'($urandom);
			else
				r.blank_time = '1;
		end else if (k < 57) begin
			r.command = CMD_OFF;
		end else if (k < 95) begin
			r.command = CMD_TICK;
		end else begin
			r.command = CMD_UNUSED;
		end
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("led_blink_sequencer regression: fail");
		$finish;
	end

	// one APB transfer: setup cycle, then access cycle until pready
	task automatic apb_access(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic apb_park();
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] unused_rd;
		apb_access(1'b1, idx, val, unused_rd);
		case (idx)
			REG_BRIGHT:    cfg_bright    = val[PCT_W-1:0];
			REG_RED_GAIN:  cfg_gain_r    = val[PCT_W-1:0];
			REG_GRN_GAIN:  cfg_gain_g    = val[PCT_W-1:0];
			REG_BLU_GAIN:  cfg_gain_b    = val[PCT_W-1:0];
			REG_SEP:       cfg_sep       = val[MS_W-1:0];
			REG_DEF_BLANK: cfg_def_blank = val[BLANK_W-1:0];
			default: ;
		endcase
		n_writes++;
	endtask

	// read every register back against the shadow
	task automatic check_regs();
		logic [31:0] rd;
		for (int i = 0; i < NUM_REGS; i++) begin
			apb_access(1'b0, 3'(i), 32'd0, rd);
			if (rd !== reg_value(3'(i))) begin
				errors++;
				$display("%0t: register %0d readback, expected %h, got %h",
					$time, i, reg_value(3'(i)), rd);
			end
		end
		apb_park();
	endtask

	// settings per phase: top extremes, all zero, over-range, then random
	task automatic configure(input int ph);
		logic [31:0] v [NUM_REGS];
		case (ph)
			0: v = '{32'd100, 32'd100, 32'd100, 32'd100, 32'hFFFF, 32'hFFFFFF};
			1: v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
			2: v = '{32'd127, 32'd127, 32'd127, 32'd127, 32'd1, 32'd1};
			default: begin
				v[REG_BRIGHT] = $urandom_range(1, 100);
				for (int i = 1; i < 4; i++)
					v[i] = ($urandom_range(0, 9) == 0) ? 32'd127 : $urandom_range(0, 100);
				v[REG_SEP] = $urandom_range(0, 1) ? $urandom_range(0, 1000)
					: $urandom_range(0, 65535);
				v[REG_DEF_BLANK] = $urandom_range(0, 24'hFFFFFF);
			end
		endcase
		write_reg(REG_BRIGHT,    v[REG_BRIGHT]);
		write_reg(REG_RED_GAIN,  v[REG_RED_GAIN]);
		write_reg(REG_GRN_GAIN,  v[REG_GRN_GAIN]);
		write_reg(REG_BLU_GAIN,  v[REG_BLU_GAIN]);
		write_reg(REG_SEP,       v[REG_SEP]);
		write_reg(REG_DEF_BLANK, v[REG_DEF_BLANK]);
		check_regs();
	endtask

	// present one request after a random gap when send_idle is set; returns at the accepting edge
	task automatic send_req(input led_req_t req, input bit known,
			input logic [RGB_W-1:0] known_rgb);
		int unsigned gap;
		led_frame_t f;
		gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.command    <= req.command;
		item_ch.color      <= req.color;
		item_ch.hold_ms    <= req.hold_ms;
		item_ch.gap_ms     <= req.gap_ms;
		item_ch.blank_time <= req.blank_time;
		do @(posedge clk); while (!item_ch.ready);
		plan_sequence(req);
		if (known) begin
			f.red   = known_rgb[23:16];
			f.green = known_rgb[15:8];
			f.blue  = known_rgb[7:0];
			f.hold  = '0;
			f.last  = 1'b1;
			pending_frames.push_back(f);
		end else begin
			foreach (fresh_frames[i])
				pending_frames.push_back(fresh_frames[i]);
		end
		if (req.command != CMD_UNUSED)
			n_reqs++;
	endtask

	// stop sending and let the block drain completely
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// result sink: random stalls while take_idle is set, compare each transfer with the oldest prediction
	initial begin
		int unsigned stall;
		led_frame_t  want;
		led_frame_t  got;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = take_idle ? $urandom_range(0, MAX_IDLE) : 0;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			got.red   = result_ch.red;
			got.green = result_ch.green;
			got.blue  = result_ch.blue;
			got.hold  = result_ch.hold_time_ms;
			got.last  = result_ch.last;
			n_frames++;
			if (pending_frames.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, got r=%h g=%h b=%h hold=%0d last=%b",
					$time, got.red, got.green, got.blue, got.hold, got.last);
			end else begin
				want = pending_frames.pop_front();
				if (want !== got) begin
					errors++;
					$display("%0t: result mismatch, expected r=%h g=%h b=%h hold=%0d last=%b,",
						$time, want.red, want.green, want.blue, want.hold, want.last);
					$display("%0t:   got r=%h g=%h b=%h hold=%0d last=%b",
						$time, got.red, got.green, got.blue, got.hold, got.last);
				end
			end
		end
	end

	// stimulus
	initial begin
		led_req_t req;
		int       cnt;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		item_ch.valid      = 1'b0;
		item_ch.command    = CMD_QUEUE;
		item_ch.color      = '0;
		item_ch.hold_ms    = '0;
		item_ch.gap_ms     = '0;
		item_ch.blank_time = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values, then the directed table under reset settings
		check_regs();
		send_idle = 1'b1;
		take_idle = 1'b1;
		foreach (directed_rows[i]) begin
			if (i == 12) begin
				send_idle = 1'b0;
				take_idle = 1'b0;
			end
			send_req(directed_rows[i].req, directed_rows[i].known, directed_rows[i].known_rgb);
		end

		// random phases, each under new register settings
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			configure(ph);
			foreach (palette[i])
				palette[i] = RGB_W'($urandom);
			send_idle = ($urandom_range(0, 3) != 0);
			take_idle = ($urandom_range(0, 3) != 0);
			cnt = 0;
			while (cnt < PHASE_ITEMS) begin
				req = make_req();
				send_req(req, 1'b0, '0);
				if (req.command != CMD_UNUSED)
					cnt++;
				if ($urandom_range(0, 24) == 0)
					send_idle = ~send_idle;
				if ($urandom_range(0, 24) == 0)
					take_idle = ~take_idle;
			end
		end
		drain();

		$display("run covered %0d input transfers, %0d checked results and %0d register writes",
			n_reqs, n_frames, n_writes);
		$display("over %0d random setting phases with random stalls on both channels", RAND_PHASES);
		if (errors == 0)
			$display("led_blink_sequencer regression: pass");
		else
			$display("led_blink_sequencer regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
